### hw/rtl/mmce_pkg.sv
package mmce_pkg;

  localparam logic [2:0] MODE_SUM8  = 3'd0;
  localparam logic [2:0] MODE_SUM16 = 3'd1;
  localparam logic [2:0] MODE_CRC8  = 3'd2;
  localparam logic [2:0] MODE_CRC16 = 3'd3;
  localparam logic [2:0] MODE_CRC32 = 3'd4;
  localparam logic [2:0] MODE_HAM   = 3'd5;
  localparam logic [2:0] MODE_ZERO6 = 3'd6;
  localparam logic [2:0] MODE_ZERO7 = 3'd7;

  localparam logic [7:0]  CRC8_POLY  = 8'h07;
  localparam logic [15:0] CRC16_POLY = 16'h1021;
  localparam logic [31:0] CRC32_POLY = 32'hEDB88320;
  localparam logic [15:0] CRC16_INIT = 16'hFFFF;
  localparam logic [31:0] CRC32_INIT = 32'hFFFFFFFF;
  localparam logic [7:0]  NIBBLE_MASK = 8'h0F;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
    logic       no_byte;
  } item_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] v, input logic [7:0] b);
    logic [7:0] c;
    c = v ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC8_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [15:0] crc16_byte(input logic [15:0] v, input logic [7:0] b);
    logic [15:0] c;
    c = v ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC16_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [31:0] crc32_byte(input logic [31:0] v, input logic [7:0] b);
    logic [31:0] c;
    c = v ^ {24'h000000, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ({1'b0, c[31:1]} ^ CRC32_POLY) : {1'b0, c[31:1]};
    end
    return c;
  endfunction

  // Hamming(7,4) of the low nibble: {p1,p2,d1,p3,d2,d3,d4}
  function automatic logic [6:0] ham_code(input logic [7:0] b);
    logic [3:0] n;
    logic       d1, d2, d3, d4;
    n  = 4'(b & NIBBLE_MASK);
    d1 = n[0];
    d2 = n[1];
    d3 = n[2];
    d4 = n[3];
    return {d1 ^ d2 ^ d4, d1 ^ d3 ^ d4, d1, d2 ^ d3 ^ d4, d2, d3, d4};
  endfunction

endpackage

### hw/rtl/mmce_update.sv
// One-byte update of the running register, plus the finished check value.
module mmce_update (
  input  logic [2:0]          mode,
  input  logic [31:0]         running,
  input  logic                at_start,
  input  mmce_pkg::item_t     item,
  output logic [31:0]         running_nxt,
  output logic [31:0]         result
);

  logic [31:0] init_val;
  logic [31:0] mask;
  logic [31:0] cur;
  logic [31:0] upd;

  always_comb begin
    unique case (mode)
      mmce_pkg::MODE_SUM8:  mask = 32'h000000FF;
      mmce_pkg::MODE_SUM16: mask = 32'h0000FFFF;
      mmce_pkg::MODE_CRC8:  mask = 32'h000000FF;
      mmce_pkg::MODE_CRC16: mask = 32'h0000FFFF;
      mmce_pkg::MODE_CRC32: mask = 32'hFFFFFFFF;
      mmce_pkg::MODE_HAM:   mask = 32'h0000007F;
      default:              mask = 32'h00000000;
    endcase
  end

  always_comb begin
    unique case (mode)
      mmce_pkg::MODE_CRC16: init_val = {16'h0000, mmce_pkg::CRC16_INIT};
      mmce_pkg::MODE_CRC32: init_val = mmce_pkg::CRC32_INIT;
      default:              init_val = 32'h00000000;
    endcase
  end

  assign cur = (at_start ? init_val : running) & mask;

  always_comb begin
    unique case (mode) inside
      mmce_pkg::MODE_SUM8,
      mmce_pkg::MODE_SUM16: upd = cur + {24'h000000, item.data_byte};
      mmce_pkg::MODE_CRC8:  upd = {24'h000000, mmce_pkg::crc8_byte(cur[7:0], item.data_byte)};
      mmce_pkg::MODE_CRC16: upd = {16'h0000, mmce_pkg::crc16_byte(cur[15:0], item.data_byte)};
      mmce_pkg::MODE_CRC32: upd = mmce_pkg::crc32_byte(cur, item.data_byte);
      mmce_pkg::MODE_HAM:   upd = cur ^ {25'h0000000, mmce_pkg::ham_code(item.data_byte)};
      default:              upd = 32'h00000000;
    endcase
  end

  assign running_nxt = item.no_byte ? cur : (upd & mask);
  assign result      = ((mode == mmce_pkg::MODE_CRC32) ? ~running_nxt : running_nxt) & mask;

endmodule

### hw/rtl/multi_mode_checksum_engine.sv
// An accepted word waits in the input stage, then updates the running register;
//   for a word marked last, the checksum goes to the output register and out_*.
// Throughput: one word per cycle unless a last word waits on a full, stalled output,
//   set by the combinational byte update of the running register (unrolled eight-step CRC).
// Reset (rst_n low, synchronous): mode 0, running value 0, next word opens a
//   message, input and output stages empty.
module multi_mode_checksum_engine (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_wr_data,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last,
  input  logic        in_no_byte,
  // results
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_checksum
);

  // Configuration register
  logic [2:0] mode_r;

  // Input stage: one registered word waiting for the update logic
  logic            s1_valid_r;
  mmce_pkg::item_t s1_item_r;

  // Message state
  logic [31:0] running_r;
  logic [31:0] running_nxt;
  logic        at_start_r;

  // Output register
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [31:0] out_checksum_r;

  logic [31:0] result;
  logic        s1_go;
  logic        in_take;

  // A non-last word never needs the output register, so it always moves on.
  // A last word moves on once the output register is empty or being drained.
  assign s1_go   = s1_valid_r && (!s1_item_r.last || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= mmce_pkg::MODE_SUM8;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.data_byte <= in_data_byte;
      s1_item_r.last      <= in_last;
      s1_item_r.no_byte   <= in_no_byte;
    end
  end

  mmce_update u_update (
    .mode        (mode_r),
    .running     (running_r),
    .at_start    (at_start_r),
    .item        (s1_item_r),
    .running_nxt (running_nxt),
    .result      (result)
  );

  // Running register and message-start flag advance with each processed word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r  <= 32'h00000000;
      at_start_r <= 1'b1;
    end else if (s1_go) begin
      running_r  <= running_nxt;
      at_start_r <= s1_item_r.last;
    end
  end

  assign out_valid_nxt = (s1_go && s1_item_r.last) || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_item_r.last) begin
      out_checksum_r <= result;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_checksum = out_checksum_r;

`ifndef ASSERT_OFF
  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with empty input stage");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && s1_item_r.last |=> out_valid && at_start_r)
    else $error("last word did not produce a result");

  a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(s1_go && s1_item_r.last))
    else $error("result appeared without a last word");

  a_zero_modes: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && (mode_r == mmce_pkg::MODE_ZERO6 || mode_r == mmce_pkg::MODE_ZERO7)
      |=> running_r == 32'h00000000)
    else $error("running value not held at zero in a zero mode");
`endif

endmodule
